@@ rtl/crc8fr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared constants, types and the CRC-8 (polynomial 0xD5) byte update for the
// framed serial receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

  localparam int FRAME_BYTES = 34;
  localparam int LINE_BYTES  = 16;

  localparam int POS_W      = 6;
  localparam int ADDR_W     = $clog2(FRAME_BYTES);
  localparam int TICK_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Number of payload characters in a good frame.
  localparam int NPAY_RAW = (2 * LINE_BYTES < FRAME_BYTES - 2) ?
                            2 * LINE_BYTES : FRAME_BYTES - 2;
  localparam int NPAY     = (NPAY_RAW < 32) ? NPAY_RAW : 32;

  localparam logic [TICK_W-1:0] GAP_RESET     = TICK_W'(50000);
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(500000);
  localparam logic [TICK_W-1:0] TICK_MAX      = '1;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]        header_value;
    logic [TICK_W-1:0] frame_gap_ticks;
    logic [TICK_W-1:0] payload_timeout_ticks;
  } cfg_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/crc8fr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_ram
// Simple dual-port synchronous RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module crc8fr_ram #(
  parameter int DEPTH  = 34,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/crc8fr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_cfg
// Configuration registers: header value, frame gap limit and payload timeout.
// ----------------------------------------------------------------------------
module crc8fr_cfg
  import crc8fr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HEADER:  cfg_d.header_value          = cfg_data_i[7:0];
        REG_GAP:     cfg_d.frame_gap_ticks       = cfg_data_i[TICK_W-1:0];
        REG_TIMEOUT: cfg_d.payload_timeout_ticks = cfg_data_i[TICK_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value          <= '0;
      cfg_q.frame_gap_ticks       <= GAP_RESET;
      cfg_q.payload_timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/crc8_framed_serial_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_serial_receiver_top
// Framed serial receiver with CRC-8 DVB-S2 check and payload readout.
// ----------------------------------------------------------------------------
// Each input transfer is either a received byte or a one microsecond tick and
// is taken whenever the block is idle and the output register is free. A byte
// produces one status item. Bytes are written into a frame RAM as they arrive;
// when a byte completes a frame that passes the header and CRC checks, the
// block walks the RAM and emits the 32 payload characters, each by a
// registered RAM read and then a load of the output register, so a good frame
// holds off new input until that walk is done, output stalls included. The RAM
// is written only on byte transfers and read only during that walk, so the
// two ports never touch the same entry in the same cycle.
// ----------------------------------------------------------------------------
module crc8_framed_serial_receiver_top
  import crc8fr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_payload_o,
  output logic [POS_W-1:0]      byte_position_o,
  output logic [7:0]            payload_char_o,
  output logic                  frame_done_o,
  output logic                  frame_good_o,
  output logic                  payload_present_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;

  cfg_t cfg;

  logic [1:0]        state_d, state_q;
  logic [POS_W-1:0]  idx_d, idx_q;
  logic [TICK_W-1:0] elapsed_d, elapsed_q;
  logic [7:0]        crc_d, crc_q;
  logic [7:0]        first_d, first_q;
  logic              flag_d, flag_q;
  logic [POS_W-1:0]  pay_idx_d, pay_idx_q;

  logic              out_valid_d, out_valid_q;
  logic              out_load;
  logic              isp_d, isp_q;
  logic [POS_W-1:0]  pos_d, pos_q;
  logic [7:0]        char_d, char_q;
  logic              done_d, done_q;
  logic              good_d, good_q;
  logic              pres_d, pres_q;
  logic              last_d, last_q;

  logic              out_free, in_fire, byte_fire;
  logic              gap_hit, to_hit, last_pos, good;
  logic [POS_W-1:0]  idx_eff;
  logic              flag_eff;
  logic [7:0]        crc_base;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  crc8fr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  crc8fr_ram #(
    .DEPTH  (FRAME_BYTES),
    .WIDTH  (8),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (byte_fire),
    .waddr_i (ADDR_W'(idx_eff)),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(pay_idx_q)),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign byte_fire  = in_fire && (kind_i == KIND_BYTE);

  // Gap checks are taken against the counter before this byte is stored.
  assign gap_hit  = elapsed_q > cfg.frame_gap_ticks;
  assign to_hit   = elapsed_q > cfg.payload_timeout_ticks;
  assign idx_eff  = gap_hit ? '0 : idx_q;
  assign flag_eff = to_hit ? 1'b0 : flag_q;
  assign crc_base = (idx_eff == '0) ? 8'h00 : crc_q;
  assign last_pos = idx_eff == POS_W'(FRAME_BYTES - 1);
  assign good     = last_pos && (first_q == cfg.header_value) &&
                    (crc_base == data_byte_i);

  assign ram_re = (state_q == ST_RD) && out_free;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    crc_d     = crc_q;
    first_d   = first_q;
    flag_d    = flag_q;
    pay_idx_d = pay_idx_q;
    out_load  = 1'b0;
    isp_d     = isp_q;
    pos_d     = pos_q;
    char_d    = char_q;
    done_d    = done_q;
    good_d    = good_q;
    pres_d    = pres_q;
    last_d    = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (kind_i == KIND_TICK)) begin
          if (elapsed_q != TICK_MAX) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end else if (byte_fire) begin
          if (idx_eff == '0) begin
            elapsed_d = '0;
            first_d   = data_byte_i;
          end
          crc_d    = crc8_update(crc_base, data_byte_i);
          idx_d    = last_pos ? '0 : idx_eff + 1'b1;
          flag_d   = flag_eff | good;
          out_load = 1'b1;
          isp_d    = 1'b0;
          pos_d    = idx_eff;
          char_d   = 8'h00;
          done_d   = last_pos;
          good_d   = good;
          pres_d   = flag_eff | good;
          last_d   = !good;
          if (good) begin
            pay_idx_d = POS_W'(1);
            state_d   = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (out_free) begin
          state_d = ST_LD;
        end
      end
      ST_LD: begin
        // The output register was emptied when the read was issued.
        out_load = 1'b1;
        isp_d    = 1'b1;
        pos_d    = pay_idx_q;
        char_d   = ram_rdata;
        done_d   = 1'b1;
        good_d   = 1'b1;
        pres_d   = flag_q;
        last_d   = pay_idx_q == POS_W'(NPAY);
        if (pay_idx_q == POS_W'(NPAY)) begin
          state_d = ST_IDLE;
        end else begin
          pay_idx_d = pay_idx_q + 1'b1;
          state_d   = ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      elapsed_q   <= '0;
      crc_q       <= '0;
      flag_q      <= 1'b0;
      pay_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      elapsed_q   <= elapsed_d;
      crc_q       <= crc_d;
      flag_q      <= flag_d;
      pay_idx_q   <= pay_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    isp_q   <= isp_d;
    pos_q   <= pos_d;
    char_q  <= char_d;
    done_q  <= done_d;
    good_q  <= good_d;
    pres_q  <= pres_d;
    last_q  <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign is_payload_o      = isp_q;
  assign byte_position_o   = pos_q;
  assign payload_char_o    = char_q;
  assign frame_done_o      = done_q;
  assign frame_good_o      = good_q;
  assign payload_present_o = pres_q;
  assign last_o            = last_q;

endmodule

@@ rtl/crc8fr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_checker
// Port-level checks for the framed serial receiver, bound to the top level.
// ----------------------------------------------------------------------------
module crc8fr_checker
  import crc8fr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             is_payload_o,
  input logic [POS_W-1:0] byte_position_o,
  input logic [7:0]       payload_char_o,
  input logic             frame_done_o,
  input logic             frame_good_o,
  input logic             payload_present_o,
  input logic             last_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_position_o) &&
    $stable(payload_char_o) && $stable(is_payload_o) && $stable(last_o))
    else $error("stalled result changed");

  // Payload characters only come from a completed good frame.
  a_payload_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_payload_o |-> frame_done_o && frame_good_o &&
    payload_present_o)
    else $error("payload item without good frame");

  // A status item ends the burst unless its frame was good.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_payload_o |-> (last_o == !frame_good_o) &&
    (!frame_good_o || (frame_done_o && payload_present_o)))
    else $error("status item last flag inconsistent");

  // While a burst is still open no new input is taken.
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> in_stall_o)
    else $error("input taken during payload burst");

endmodule

bind crc8_framed_serial_receiver_top crc8fr_checker u_crc8fr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .is_payload_o      (is_payload_o),
  .byte_position_o   (byte_position_o),
  .payload_char_o    (payload_char_o),
  .frame_done_o      (frame_done_o),
  .frame_good_o      (frame_good_o),
  .payload_present_o (payload_present_o),
  .last_o            (last_o)
);

@@ tb/crc8_framed_serial_receiver_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_serial_receiver_top_test
// Self-checking testbench for the framed serial receiver. Byte and tick
// transfers go into the block with random bursts and gaps, while the output
// side stalls on its own random pattern. A scoreboard keeps its own frame
// state and CRC, predicts the status and payload items of every accepted
// byte, and checks each output transfer field by field in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                         is_payload;
  logic [crc8fr_pkg::POS_W-1:0] pos;
  logic [7:0]                   ch;
  logic                         done;
  logic                         good;
  logic                         present;
  logic                         last;
} rx_item_t;

class frame_scoreboard;
  logic [7:0]  hdr_val;
  logic [19:0] gap_lim;
  logic [19:0] tmo_lim;
  int          next_pos;
  logic [19:0] elapsed;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_mem [crc8fr_pkg::FRAME_BYTES];
  logic        present_flag;
  rx_item_t    expected_q [$];
  int          errors;
  int          checked;

  function new();
    hdr_val      = 8'h00;
    gap_lim      = 20'd50000;
    tmo_lim      = 20'd500000;
    next_pos     = 0;
    elapsed      = '0;
    crc_acc      = 8'h00;
    present_flag = 1'b0;
    errors       = 0;
    checked      = 0;
  endfunction

  static function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ crc8fr_pkg::CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function void set_reg(logic [crc8fr_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
    case (idx)
      crc8fr_pkg::REG_HEADER:  hdr_val = val[7:0];
      crc8fr_pkg::REG_GAP:     gap_lim = val;
      crc8fr_pkg::REG_TIMEOUT: tmo_lim = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_input(logic k, logic [7:0] b);
    int       pos;
    int       npay;
    bit       done;
    bit       good;
    rx_item_t r;
    if (k == crc8fr_pkg::KIND_TICK) begin
      if (elapsed != crc8fr_pkg::TICK_MAX) elapsed = elapsed + 1'b1;
      return;
    end
    // Both limits are compared before the byte is stored.
    if (elapsed > gap_lim) next_pos = 0;
    if (elapsed > tmo_lim) present_flag = 1'b0;
    if (next_pos >= crc8fr_pkg::FRAME_BYTES) next_pos = 0;
    if (next_pos == 0) begin
      elapsed = '0;
      crc_acc = 8'h00;
    end
    pos            = next_pos;
    frame_mem[pos] = b;
    done           = 1'b0;
    good           = 1'b0;
    if (pos + 1 < crc8fr_pkg::FRAME_BYTES) begin
      crc_acc  = crc_step(crc_acc, b);
      next_pos = pos + 1;
    end else begin
      done     = 1'b1;
      next_pos = 0;
      good     = (frame_mem[0] == hdr_val) && (crc_acc == b);
      if (good) present_flag = 1'b1;
    end
    npay = 0;
    if (good) begin
      npay = 2 * crc8fr_pkg::LINE_BYTES;
      if (npay > crc8fr_pkg::FRAME_BYTES - 2) npay = crc8fr_pkg::FRAME_BYTES - 2;
      if (npay > 32) npay = 32;
    end
    r = '{is_payload: 1'b0, pos: pos[5:0], ch: 8'h00, done: done, good: good,
          present: present_flag, last: (npay == 0)};
    expected_q.push_back(r);
    for (int i = 1; i <= npay; i++) begin
      r = '{is_payload: 1'b1, pos: i[5:0], ch: frame_mem[i], done: 1'b1, good: 1'b1,
            present: present_flag, last: (i == npay)};
      expected_q.push_back(r);
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 60) $display("MISMATCH: %s", msg);
  endtask

  task check_result(rx_item_t got);
    rx_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("output transfer %h with no result expected", got));
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.is_payload !== want.is_payload)
      report($sformatf("result %0d is_payload: expected %0b, got %0b",
                       checked, want.is_payload, got.is_payload));
    if (got.pos !== want.pos)
      report($sformatf("result %0d byte_position: expected %0d, got %0d",
                       checked, want.pos, got.pos));
    if (got.ch !== want.ch)
      report($sformatf("result %0d payload_char: expected %h, got %h",
                       checked, want.ch, got.ch));
    if (got.done !== want.done)
      report($sformatf("result %0d frame_done: expected %0b, got %0b",
                       checked, want.done, got.done));
    if (got.good !== want.good)
      report($sformatf("result %0d frame_good: expected %0b, got %0b",
                       checked, want.good, got.good));
    if (got.present !== want.present)
      report($sformatf("result %0d payload_present: expected %0b, got %0b",
                       checked, want.present, got.present));
    if (got.last !== want.last)
      report($sformatf("result %0d last: expected %0b, got %0b",
                       checked, want.last, got.last));
  endtask

  task check_leftover();
    if (expected_q.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_q.size()));
  endtask
endclass

module crc8_framed_serial_receiver_top_test;
  import crc8fr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 2000000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  kind_i;
  logic [7:0]            data_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  is_payload_o;
  logic [POS_W-1:0]      byte_position_o;
  logic [7:0]            payload_char_o;
  logic                  frame_done_o;
  logic                  frame_good_o;
  logic                  payload_present_o;
  logic                  last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  frame_scoreboard sb = new();

  int          burst_left  = 0;
  int          gap_max     = 0;
  int          stall_max   = 0;
  int          hold_len    = 0;
  int          bytes_sent  = 0;
  int unsigned cycle_count = 0;

  crc8_framed_serial_receiver_top DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{is_payload: is_payload_o, pos: byte_position_o, ch: payload_char_o,
                        done: frame_done_o, good: frame_good_o,
                        present: payload_present_o, last: last_o});
  end

  // Output side: alternating free and stalled runs, or one long hold-off on request.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        if (stall_max > 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, stall_max)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_item(input logic k, input logic [7:0] b);
    int idle;
    if (burst_left == 0) begin
      idle = $urandom_range(0, gap_max);
      if (idle > 0) begin
        in_valid_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(k, b);
    if (k == KIND_BYTE) bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_frame(input int len, input bit bad_hdr, input bit bad_crc,
                            input int tick_pct, input bit extremes);
    logic [7:0] acc;
    logic [7:0] b;
    acc = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) < tick_pct) send_item(KIND_TICK, 8'($urandom));
      if (i == 0)
        b = bad_hdr ? sb.hdr_val ^ 8'($urandom_range(1, 255)) : sb.hdr_val;
      else if (i == FRAME_BYTES - 1)
        b = bad_crc ? acc ^ 8'($urandom_range(1, 255)) : acc;
      else if (extremes)
        b = i[0] ? 8'hFF : 8'h00;
      else
        b = 8'($urandom);
      acc = crc8_update(acc, b);
      send_item(KIND_BYTE, b);
    end
  endtask

  // Puts the next byte at frame position 0, by a long gap where the limit is
  // short and by filler bytes otherwise.
  task automatic send_align();
    int n;
    if (sb.gap_lim < 64) begin
      n = sb.gap_lim + 1;
      repeat (n) send_item(KIND_TICK, 8'($urandom));
    end else begin
      n = (FRAME_BYTES - sb.next_pos) % FRAME_BYTES;
      repeat (n) send_item(KIND_BYTE, 8'($urandom));
    end
  endtask

  task automatic run_phase(input logic [7:0] hdr, input logic [19:0] gap,
                           input logic [19:0] tmo, input int idle_max, input int stall_len,
                           input int tick_pct, input int target, input bit frames_only,
                           input bit squeeze);
    int stop;
    int pick;
    settle();
    write_reg(REG_HEADER, {12'h000, hdr});
    write_reg(REG_GAP, gap);
    write_reg(REG_TIMEOUT, tmo);
    gap_max   = idle_max;
    stall_max = stall_len;
    stop      = bytes_sent + target;
    if (squeeze) begin
      // The output side holds off while a good frame and more bytes are offered.
      hold_len = HOLD_CYCLES;
      send_align();
      send_frame(FRAME_BYTES, 1'b0, 1'b0, 0, 1'b0);
      repeat (12) send_item(KIND_BYTE, 8'($urandom));
      wait_drain();
    end
    while (bytes_sent < stop) begin
      pick = frames_only ? $urandom_range(0, 6) : $urandom_range(0, 9);
      case (pick)
        7: send_frame($urandom_range(1, FRAME_BYTES - 1), 1'b0, 1'b0, tick_pct, 1'b0);
        8: repeat ($urandom_range(1, 10)) send_item(1'($urandom), 8'($urandom));
        9: begin
          if (sb.gap_lim < 64)
            repeat ($urandom_range(sb.gap_lim + 1, 2 * sb.gap_lim + 2))
              send_item(KIND_TICK, 8'($urandom));
          else
            repeat ($urandom_range(1, 6)) send_item(KIND_BYTE, 8'($urandom));
        end
        default: begin
          send_align();
          send_frame(FRAME_BYTES, $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                     tick_pct, 1'b0);
          if ($urandom_range(0, 7) == 0) wait_drain();
        end
      endcase
    end
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_BYTE;
    data_byte_i <= 8'h00;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_HEADER;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a good frame whose payload swings between all zeros and all ones.
    stall_max = 3;
    send_frame(FRAME_BYTES, 1'b0, 1'b0, 0, 1'b1);

    // Header written wider than its field, both limits at zero, then an unused index.
    settle();
    write_reg(REG_HEADER, 20'hFFF5A);
    write_reg(REG_GAP, '0);
    write_reg(REG_TIMEOUT, '0);
    write_reg(REG_UNUSED, '1);
    send_item(KIND_TICK, 8'($urandom));
    send_frame(FRAME_BYTES, 1'b0, 1'b0, 0, 1'b0);
    send_item(KIND_BYTE, 8'h12);
    send_item(KIND_TICK, 8'($urandom));
    send_item(KIND_BYTE, 8'h34);

    run_phase(8'hA5, 20'd12, 20'd40, 4, 6, 8, 55, 1'b0, 1'b1);
    run_phase(8'hFF, 20'd1, 20'd1, 0, 0, 1, 55, 1'b0, 1'b0);
    run_phase(8'h00, 20'hFFFFF, 20'hFFFFF, 8, 14, 10, 55, 1'b1, 1'b0);
    run_phase(8'h3C, 20'd30, 20'd8, 3, 4, 10, 55, 1'b0, 1'b0);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_leftover();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
